/* design/three_stacks_shared_memory_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the three stacks core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_STACKS_SHARED_MEMORY_CORE_MACROS_SVH
`define THREE_STACKS_SHARED_MEMORY_CORE_MACROS_SVH

// same-cycle implication
`define TSM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsm assertion failed");

// next-cycle implication
`define TSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsm assertion failed");

`endif

/* design/tsm_pkg.sv */
// ----------------------------------------------------------------------------
// tsm_pkg
// Types and constants shared by the three stacks core modules.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int NUM_STACKS  = 3;
    localparam int MAX_DEPTH   = 16;
    localparam int STORE_WORDS = NUM_STACKS * MAX_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int CNT_W       = $clog2(MAX_DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_TOP  = 2'd2;

    localparam logic [1:0] SEL_INVALID = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [1:0]               stack_select;
        logic signed [DATA_W-1:0] push_value;
    } tsm_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
    } tsm_out_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_direct;
        logic load_held;
    } tsm_ctl_t;

    // datapath -> controller status
    typedef struct packed {
        logic need_read;
    } tsm_sts_t;

endpackage

/* design/three_stacks_shared_memory_core.sv */
// ----------------------------------------------------------------------------
// three_stacks_shared_memory_core
// Three fixed-size stacks in one shared memory, push / pop / read-top.
// ----------------------------------------------------------------------------
// One transaction in gives one result out. Push, pop and reads of an empty or
// invalid stack load the result register in the execute state, or in the finish
// state while the output is still busy; a read of a nonempty stack goes through
// the registered read port of the stack memory and loads it in the finish state.
// One item is in flight at a time, so a new item is accepted only after the last
// one's result is loaded. A finished result waiting on res_ready does not block
// acceptance of the next item, which waits only at its own delivery. Stack k
// starts at slot k times the capacity (capped at 16); stack select 3 reports
// full on push and empty on pop and read. Write cfg_wdata through cfg_we only
// while no item is in flight.
// ----------------------------------------------------------------------------
module three_stacks_shared_memory_core
    import tsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  tsm_in_t          cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output tsm_out_t         res,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    tsm_ctl_t ctl;
    tsm_sts_t sts;

    tsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    tsm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .res       (res)
    );

endmodule

/* design/tsm_ctrl.sv */
// ----------------------------------------------------------------------------
// tsm_ctrl
// Sequencer for the three stacks core: accept, execute, deliver result.
// ----------------------------------------------------------------------------
`include "three_stacks_shared_memory_core_macros.svh"

module tsm_ctrl
    import tsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    output logic     res_valid,
    input  logic     res_ready,
    input  tsm_sts_t sts,
    output tsm_ctl_t ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    assign out_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                // results without a memory read go straight out when possible
                if (!sts.need_read && out_free)
                begin
                    ctl.load_direct = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ctl.load_held = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctl.load_direct || ctl.load_held)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `TSM_ASSERT_NEXT(a_accept_to_exec, cmd_valid && cmd_ready, state_reg == S_EXEC)
    `TSM_ASSERT_NEXT(a_exec_one_cycle, state_reg == S_EXEC, state_reg != S_EXEC)
    `TSM_ASSERT_IMPL(a_no_overwrite, ctl.load_direct || ctl.load_held, out_free)

endmodule

/* design/tsm_dp.sv */
// ----------------------------------------------------------------------------
// tsm_dp
// Datapath: capacity register, fill counts, shared stack memory, result regs.
// ----------------------------------------------------------------------------
`include "three_stacks_shared_memory_core_macros.svh"

module tsm_dp
    import tsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  tsm_in_t          cmd,
    input  tsm_ctl_t         ctl,
    output tsm_sts_t         sts,
    output tsm_out_t         res
);

    logic [CAP_W-1:0]         cap_reg;
    logic [CNT_W-1:0]         eff_cap;

    logic [1:0]               op_reg;
    logic [1:0]               sel_reg;
    logic signed [DATA_W-1:0] val_reg;

    logic [CNT_W-1:0]         count_reg  [NUM_STACKS];
    logic [CNT_W-1:0]         count_next [NUM_STACKS];
    logic [CNT_W-1:0]         cur_cnt;
    logic                     cnt_ok;

    logic                     full;
    logic                     empty;
    logic [ADDR_W-1:0]        wr_slot;
    logic [ADDR_W-1:0]        rd_slot;
    logic                     mem_we;
    logic                     mem_re;

    logic signed [DATA_W-1:0] mem [STORE_WORDS];
    logic signed [DATA_W-1:0] rdata_reg;

    tsm_out_t                 res_calc;
    tsm_out_t                 hold_reg;
    logic                     from_mem_reg;
    tsm_out_t                 res_reg;

    // capacity saturates at the physical depth
    always_comb
    begin
        if (32'(cap_reg) > MAX_DEPTH)
            eff_cap = CNT_W'(MAX_DEPTH);
        else
            eff_cap = CNT_W'(cap_reg);
    end

    always_comb
    begin
        case (sel_reg)
            2'd0:    cur_cnt = count_reg[0];
            2'd1:    cur_cnt = count_reg[1];
            2'd2:    cur_cnt = count_reg[2];
            default: cur_cnt = '0;
        endcase
    end

    assign full    = (sel_reg == SEL_INVALID) || (cur_cnt >= eff_cap);
    assign empty   = (sel_reg == SEL_INVALID) || (cur_cnt == '0);
    assign wr_slot = ADDR_W'(sel_reg) * ADDR_W'(eff_cap) + ADDR_W'(cur_cnt);
    assign rd_slot = wr_slot - ADDR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        res_calc   = '{status: ST_OK, top_value: '0};
        case (op_reg)
            OP_PUSH:
            begin
                if (full)
                begin
                    res_calc.status = ST_FULL;
                end
                else
                begin
                    mem_we = ctl.exec;
                    if (ctl.exec)
                        count_next[sel_reg] = cur_cnt + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (empty)
                    res_calc.status = ST_EMPTY;
                else if (ctl.exec)
                    count_next[sel_reg] = cur_cnt - CNT_W'(1);
            end
            OP_TOP:
            begin
                if (empty)
                begin
                    res_calc.status    = ST_EMPTY;
                    res_calc.top_value = INT_MIN;
                end
                else
                begin
                    mem_re = ctl.exec;
                end
            end
            default:
            begin
                res_calc = '{status: ST_OK, top_value: '0};
            end
        endcase
    end

    assign sts.need_read = (op_reg == OP_TOP) && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            for (int i = 0; i < NUM_STACKS; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            count_reg <= count_next;
        end
    end

    // item, held result and output payload
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            op_reg  <= cmd.opcode;
            sel_reg <= cmd.stack_select;
            val_reg <= cmd.push_value;
        end
        if (ctl.exec)
        begin
            hold_reg     <= res_calc;
            from_mem_reg <= sts.need_read;
        end
        if (ctl.load_direct)
            res_reg <= res_calc;
        else if (ctl.load_held)
            res_reg <= from_mem_reg ? tsm_out_t'{status: ST_OK, top_value: rdata_reg}
                                    : hold_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_slot] <= val_reg;
        if (mem_re)
            rdata_reg <= mem[rd_slot];
    end

    assign res = res_reg;

    assign cnt_ok = (count_reg[0] <= CNT_W'(MAX_DEPTH))
                 && (count_reg[1] <= CNT_W'(MAX_DEPTH))
                 && (count_reg[2] <= CNT_W'(MAX_DEPTH));

    `TSM_ASSERT_IMPL(a_no_write_when_full, mem_we, !full && op_reg == OP_PUSH)
    `TSM_ASSERT_IMPL(a_count_bound, 1'b1, cnt_ok)
    `TSM_ASSERT_IMPL(a_read_only_nonempty, mem_re, !empty && sel_reg != SEL_INVALID)

endmodule
